// ===== hdl/fqr_pkg.sv =====
// Package with operation codes, status codes and controller states of the reversible queue.
package fqr_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] MODE_ENQ  = 3'd0;
    localparam logic [2:0] MODE_DEQ  = 3'd1;
    localparam logic [2:0] MODE_PEEK = 3'd2;
    localparam logic [2:0] MODE_DISP = 3'd3;
    localparam logic [2:0] MODE_REV  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

// ===== hdl/fqr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fifo_queue_with_reverse_core.sv =====
// Top level of the bounded FIFO with constant-time reverse, kept in a ring RAM.
//
//  channel   ports                              handshake
//  -------   --------------------------------   ------------------------------
//  command   i_mode, i_value                    i_start high while o_busy low
//  result    o_status, o_data, o_last           o_valid high with each word
//
//  Enqueue, reverse and error results appear in the cycle after the command; the
//  block stays ready. Dequeue and peek read the ring RAM (registered read data)
//  and give their word through the result register, busy while in the read state.
//  Display streams one word per cycle from the read state, paced by the single
//  RAM read port, with its first word timed like a dequeue result.
//  Reset empties the queue at once. The receiver cannot stall results.
module fifo_queue_with_reverse_core
    import fqr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [2:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;

    logic [AW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic              r_back, n_back;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_end, n_end;
    logic              r_valid, n_valid;
    logic [1:0]        r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_last, n_last;

    logic              accept;
    logic              empty;
    logic              full;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic back,
                                              input logic [AW-1:0] pos);
        logic [AW:0] s;
        if (back) begin
            s = {1'b0, front} - {1'b0, pos};
            if (front < pos) begin
                s = s + (AW+1)'(DEPTH);
            end
        end else begin
            s = {1'b0, front} + {1'b0, pos};
            if (s >= (AW+1)'(DEPTH)) begin
                s = s - (AW+1)'(DEPTH);
            end
        end
        return s[AW-1:0];
    endfunction

    assign accept = i_start && (r_state == S_IDLE);
    assign empty  = (r_count == '0);
    assign full   = (r_count == CW'(DEPTH));

    fqr_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_value),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !empty &&
                    (i_mode == MODE_DEQ || i_mode == MODE_PEEK || i_mode == MODE_DISP)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_pos == r_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and RAM control
    always_comb begin
        o_busy    = (r_state != S_IDLE);
        ram_we    = 1'b0;
        ram_waddr = slot_of(r_front, r_back, r_count[AW-1:0]);
        ram_re    = 1'b0;
        ram_raddr = r_front;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_ENQ:  ram_we = !full;
                        MODE_DEQ,
                        MODE_PEEK,
                        MODE_DISP: ram_re = !empty;
                        default:   ram_re = 1'b0;
                    endcase
                end
            end
            S_READ: begin
                ram_re    = (r_pos != r_end);
                ram_raddr = slot_of(r_front, r_back, r_pos[AW-1:0]);
            end
            default: ram_re = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_back   = r_back;
        n_pos    = r_pos;
        n_end    = r_end;
        n_valid  = 1'b0;
        n_status = STAT_OK;
        n_data   = '0;
        n_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos = CW'(1);
                    n_end = CW'(1);
                    unique case (i_mode)
                        MODE_ENQ: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_DEQ, MODE_PEEK: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                            end else if (i_mode == MODE_DEQ) begin
                                n_front = slot_of(r_front, r_back, AW'(1));
                                n_count = r_count - 1'b1;
                            end
                        end
                        MODE_DISP: begin
                            n_end = r_count;
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                            end
                        end
                        MODE_REV: begin
                            n_valid = 1'b1;
                            if (empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_front = slot_of(r_front, r_back, AW'(r_count - 1'b1));
                                n_back  = !r_back;
                            end
                        end
                        default: n_valid = 1'b0;
                    endcase
                end
            end
            S_READ: begin
                n_valid = 1'b1;
                n_data  = ram_rdata;
                n_last  = (r_pos == r_end);
                if (r_pos != r_end) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_back  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_back  <= n_back;
            r_valid <= n_valid;
        end
        r_pos    <= n_pos;
        r_end    <= n_end;
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_last   = r_last;

endmodule

// ===== sim/fqr_result_checker.sv =====
// Checker that models the reversible queue and compares every result word.
`timescale 1ns / 100ps
module fqr_result_checker
    import fqr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [2:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_valid,
    input  logic [1:0]               i_status,
    input  logic signed [DATA_W-1:0] i_data,
    input  logic                     i_last,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_commands,
    output int                       o_checked,
    output int                       o_full_hits
);

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_word;

    t_word                    pending_results[$];
    logic signed [DATA_W-1:0] ring [DEPTH];
    int                       front;
    int                       count;
    logic                     backward;

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_commands  = 0;
        o_checked   = 0;
        o_full_hits = 0;
        front       = 0;
        count       = 0;
        backward    = 1'b0;
    end

    function automatic int ring_slot(input int pos);
        if (backward) begin
            return (front + DEPTH - (pos % DEPTH)) % DEPTH;
        end
        return (front + pos) % DEPTH;
    endfunction

    function automatic void expect_word(input logic [1:0] st,
                                        input logic signed [DATA_W-1:0] d,
                                        input logic l);
        t_word w;
        w.status = st;
        w.data   = d;
        w.last   = l;
        pending_results.push_back(w);
        if (st == STAT_FULL) begin
            o_full_hits++;
        end
    endfunction

    task automatic apply_command(input logic [2:0] m, input logic signed [DATA_W-1:0] v);
        int i;
        case (m)
            MODE_ENQ: begin
                if (count >= DEPTH) begin
                    expect_word(STAT_FULL, '0, 1'b1);
                end else begin
                    ring[ring_slot(count)] = v;
                    count++;
                    expect_word(STAT_OK, '0, 1'b1);
                end
            end
            MODE_DEQ: begin
                if (count == 0) begin
                    expect_word(STAT_EMPTY, '0, 1'b1);
                end else begin
                    expect_word(STAT_OK, ring[ring_slot(0)], 1'b1);
                    front = ring_slot(1);
                    count--;
                end
            end
            MODE_PEEK: begin
                if (count == 0) begin
                    expect_word(STAT_EMPTY, '0, 1'b1);
                end else begin
                    expect_word(STAT_OK, ring[ring_slot(0)], 1'b1);
                end
            end
            MODE_DISP: begin
                if (count == 0) begin
                    expect_word(STAT_EMPTY, '0, 1'b1);
                end else begin
                    for (i = 0; i < count; i++) begin
                        expect_word(STAT_OK, ring[ring_slot(i)], i == count - 1);
                    end
                end
            end
            MODE_REV: begin
                if (count == 0) begin
                    expect_word(STAT_EMPTY, '0, 1'b1);
                end else begin
                    front    = ring_slot(count - 1);
                    backward = !backward;
                    expect_word(STAT_OK, '0, 1'b1);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic note_mismatch(input bit has_want, input t_word want, input t_word got);
        o_errors++;
        if (o_errors <= 10) begin
            if (has_want) begin
                $display("%0t: expected status %0d data %0d last %0d, got status %0d data %0d last %0d",
                         $realtime, want.status, want.data, want.last,
                         got.status, got.data, got.last);
            end else begin
                $display("%0t: unexpected word status %0d data %0d last %0d",
                         $realtime, got.status, got.data, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            pending_results.delete();
            front    = 0;
            count    = 0;
            backward = 1'b0;
        end else begin
            if (i_valid) begin
                got.status = i_status;
                got.data   = i_data;
                got.last   = i_last;
                if (pending_results.size() == 0) begin
                    want = '0;
                    note_mismatch(1'b0, want, got);
                end else begin
                    want = pending_results.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        note_mismatch(1'b1, want, got);
                    end
                end
            end
            if (i_start && !i_busy) begin
                o_commands++;
                apply_command(i_mode, i_value);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: drives commands into the reversible queue and reports the verdict.
`timescale 1ns / 100ps
module testbench;
    import fqr_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [2:0]               i_mode;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_data;
    logic                     o_last;

    int errors;
    int pending;
    int commands;
    int checked;
    int full_hits;
    int idle_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fifo_queue_with_reverse_core #(
        .DEPTH(64)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_mode  (i_mode),
        .i_value (i_value),
        .o_valid (o_valid),
        .o_status(o_status),
        .o_data  (o_data),
        .o_last  (o_last)
    );

    fqr_result_checker #(
        .DEPTH(64)
    ) result_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_busy     (o_busy),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .i_valid    (o_valid),
        .i_status   (o_status),
        .i_data     (o_data),
        .i_last     (o_last),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_commands (commands),
        .o_checked  (checked),
        .o_full_hits(full_hits)
    );

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'sh7fffffff;
        if (r < 6) return 32'sh80000000;
        if (r < 9) return '0;
        if (r < 12) return -32'sd1;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_mode(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 3'($urandom_range(5, 7));
        if (filling) begin
            if (r < 86) return MODE_ENQ;
            if (r < 90) return MODE_DEQ;
            if (r < 94) return MODE_PEEK;
            if (r < 97) return MODE_REV;
            return MODE_DISP;
        end
        if (r < 16) return MODE_ENQ;
        if (r < 60) return MODE_DEQ;
        if (r < 72) return MODE_PEEK;
        if (r < 84) return MODE_REV;
        return MODE_DISP;
    endfunction

    task automatic send_cmd(input logic [2:0] m, input logic signed [DATA_W-1:0] v);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            i_mode  <= 3'($urandom);
            i_value <= $urandom;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_mode  <= m;
        i_value <= v;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        i_start  = 1'b0;
        i_mode   = MODE_ENQ;
        i_value  = '0;
        idle_pct = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(MODE_PEEK, '0);
        send_cmd(MODE_DEQ, '0);
        send_cmd(MODE_DISP, '0);
        send_cmd(MODE_REV, '0);
        send_cmd(MODE_ENQ, 32'sh7fffffff);
        send_cmd(MODE_ENQ, 32'sh80000000);
        send_cmd(MODE_ENQ, '0);
        send_cmd(MODE_ENQ, -32'sd1);
        send_cmd(3'd5, $urandom);
        send_cmd(3'd6, $urandom);
        send_cmd(3'd7, $urandom);
        send_cmd(MODE_PEEK, '0);
        send_cmd(MODE_DISP, '0);
        send_cmd(MODE_REV, '0);
        send_cmd(MODE_DISP, '0);
        send_cmd(MODE_PEEK, '0);
        send_cmd(MODE_DEQ, '0);
        send_cmd(MODE_ENQ, 32'sh12345678);
        send_cmd(MODE_DISP, '0);
        send_cmd(MODE_REV, '0);
        repeat (5) send_cmd(MODE_DEQ, '0);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 77 : (ph == 2) ? 27 : 0;
            for (int k = 0; k < 112; k++) begin
                send_cmd(pick_mode(k < 70), pick_value());
            end
        end

        idle_pct = 0;
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);

        $display("Checked %0d result words from %0d commands; %0d enqueues hit a full queue.",
                 checked, commands, full_hits);
        $display("Pacing ran back to back, then with sender gaps in 77 and 27 of 100 cycles.");
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== fifo_queue_with_reverse_core.f =====
hdl/fqr_pkg.sv
hdl/fqr_ram.sv
hdl/fifo_queue_with_reverse_core.sv
sim/fqr_result_checker.sv
sim/testbench.sv
